// File: rtl/dqs_pkg.sv
// dqs_pkg: shared types and constants for the double-ended queue with search
// command and result words, operation and status codes, cell control struct
// no dependencies
package dqs_pkg;

	localparam int DEPTH   = 16;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int WORD_W  = 32;
	localparam int OCC_W   = 5;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_SEARCH     = 3'd4
	} op_e;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_e;

	typedef enum logic {
		S_IDLE  = 1'b0,
		S_REPLY = 1'b1
	} state_e;

	localparam logic signed [WORD_W-1:0] EMPTY_POP_WORD = -32'sd1;

	typedef struct packed {
		logic [2:0]               operation;
		logic signed [WORD_W-1:0] value;
	} in_word_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] result_value;
		logic [1:0]               status;
		logic                     found;
		logic [OCC_W-1:0]         occupancy;
	} out_word_t;

	typedef struct packed {
		logic                     shift_right;
		logic                     shift_left;
		logic                     load_back;
		logic                     search;
		logic [CNT_W-1:0]         count;
		logic signed [WORD_W-1:0] value;
	} cell_ctl_t;

endpackage

// File: rtl/dqs_cell.sv
// dqs_cell: one storage cell of the queue row, holds one word
// shifts with its neighbors, takes a back push, compares for search
// depends on dqs_pkg
module dqs_cell
	import dqs_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [CNT_W-1:0]         idx,
	input  cell_ctl_t                ctl,
	input  logic signed [WORD_W-1:0] left_data,
	input  logic signed [WORD_W-1:0] right_data,
	output logic signed [WORD_W-1:0] data_q,
	output logic signed [WORD_W-1:0] tap,
	output logic                     match_q
);

	logic held;
	logic is_tail;
	logic is_last;

	assign held    = idx < ctl.count;
	assign is_tail = idx == ctl.count;
	assign is_last = (idx + CNT_W'(1)) == ctl.count;
	assign tap     = is_last ? data_q : '0;

	always_ff @(posedge clk) begin
		if (ctl.shift_right) begin
			data_q <= left_data;
		end else if (ctl.shift_left) begin
			data_q <= right_data;
		end else if (ctl.load_back && is_tail) begin
			data_q <= ctl.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else begin
			match_q <= ctl.search && held && (data_q == ctl.value);
		end
	end

endmodule

// File: rtl/double_ended_queue_with_search_top.sv
// double_ended_queue_with_search_top: bounded deque of signed words with search
// sequencer and count register driving a row of dqs_cell instances
// depends on dqs_pkg, dqs_cell
//
// For every command word, the edge that accepts it updates the cell row and
// latches the popped word and each cell's compare, and in the
// following cycle done is high for exactly one cycle with the result word,
// while busy holds off the next command. The front of the queue always sits
// in cell zero; a front push or pop shifts the whole row one cell. The
// receiver cannot stall: a result must be taken in the cycle it is shown.
// No clearing pass after reset; the queue is empty once reset is released.
module double_ended_queue_with_search_top
	import dqs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_word_t  cmd,
	output logic      done,
	output out_word_t result
);

	state_e state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic signed [WORD_W-1:0] res_q;
	status_e status_q;

	logic accept;
	logic full;
	logic empty;
	logic is_push;
	logic is_pop;
	cell_ctl_t ctl;
	status_e status_d;
	logic signed [WORD_W-1:0] res_d;
	logic signed [WORD_W-1:0] back_word;

	logic signed [WORD_W-1:0] data_w [DEPTH];
	logic signed [WORD_W-1:0] tap_w  [DEPTH];
	logic [DEPTH-1:0]         match_w;

	assign accept = start && !busy;
	assign full   = count_q == CNT_W'(DEPTH);
	assign empty  = count_q == '0;
	assign is_push = (cmd.operation == OP_PUSH_FRONT) || (cmd.operation == OP_PUSH_BACK);
	assign is_pop  = (cmd.operation == OP_POP_FRONT) || (cmd.operation == OP_POP_BACK);

	always_comb begin
		ctl.shift_right = accept && (cmd.operation == OP_PUSH_FRONT) && !full;
		ctl.shift_left  = accept && (cmd.operation == OP_POP_FRONT) && !empty;
		ctl.load_back   = accept && (cmd.operation == OP_PUSH_BACK) && !full;
		ctl.search      = accept && (cmd.operation == OP_SEARCH);
		ctl.count       = count_q;
		ctl.value       = cmd.value;
	end

	always_comb begin
		back_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			back_word = back_word | tap_w[i];
		end
	end

	always_comb begin
		status_d = ST_OK;
		res_d    = '0;
		if (is_push && full) begin
			status_d = ST_FULL;
		end else if (is_pop && empty) begin
			status_d = ST_EMPTY;
			res_d    = EMPTY_POP_WORD;
		end else if (cmd.operation == OP_POP_FRONT) begin
			res_d = data_w[0];
		end else if (cmd.operation == OP_POP_BACK) begin
			res_d = back_word;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		dqs_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.idx        (CNT_W'(i)),
			.ctl        (ctl),
			.left_data  ((i == 0) ? cmd.value : data_w[(i == 0) ? 0 : i - 1]),
			.right_data (data_w[(i == DEPTH - 1) ? i : i + 1]),
			.data_q     (data_w[i]),
			.tap        (tap_w[i]),
			.match_q    (match_w[i])
		);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_REPLY;
				end
			end
			S_REPLY: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (ctl.shift_right || ctl.load_back) begin
				count_q <= count_q + CNT_W'(1);
			end else if (accept && is_pop && !empty) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q    <= res_d;
			status_q <= status_d;
		end
	end

	assign busy = state_q == S_REPLY;
	assign done = state_q == S_REPLY;

	always_comb begin
		result.result_value = res_q;
		result.status       = status_q;
		result.found        = |match_w;
		result.occupancy    = OCC_W'(count_q);
	end

endmodule

// File: rtl/dqs_checker.sv
// dqs_checker: port-level checks on the double-ended queue with search
// bound to double_ended_queue_with_search_top
// depends on dqs_pkg
module dqs_checker
	import dqs_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input in_word_t  cmd,
	input logic      done,
	input out_word_t result
);

	a_accept_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done)
		else $error("accepted word gave no result");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result without accepted word");

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.occupancy <= OCC_W'(DEPTH))
		else $error("occupancy beyond depth");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_EMPTY |->
			result.result_value == EMPTY_POP_WORD && result.occupancy == '0)
		else $error("empty pop word wrong");

	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_FULL |-> result.occupancy == OCC_W'(DEPTH))
		else $error("full status without full queue");

endmodule

bind double_ended_queue_with_search_top dqs_checker u_dqs_checker (.*);

// File: bench/tb_double_ended_queue_with_search_top.sv
`timescale 1ns / 1ps
// tb_double_ended_queue_with_search_top: self-checking bench for the searchable deque
// drives command words through start/busy and checks every done word against a
// queue-based prediction; depends on dqs_pkg and double_ended_queue_with_search_top
module tb_double_ended_queue_with_search_top;
	import dqs_pkg::*;

	localparam int          IDLE_LIMIT  = 1000;
	localparam int          N_WORDS     = 1100;
	localparam int          SHOWN_ERRS  = 10;
	localparam logic [2:0]  OP_CODE_MAX = 3'd7;

	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_SEARCH} mix_e;

	class deque_scoreboard;
		logic signed [WORD_W-1:0] held[$];
		out_word_t                expected_q[$];
		int                       errors;

		function new();
			errors = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_failure(string msg);
			errors++;
			if (errors <= SHOWN_ERRS) begin
				$display("[%0t] %s", $realtime, msg);
			end
		endfunction

		function void note_command(in_word_t w);
			out_word_t e;
			e = '0;
			case (w.operation)
				OP_PUSH_FRONT, OP_PUSH_BACK: begin
					if (held.size() >= DEPTH) begin
						e.status = ST_FULL;
					end else if (w.operation == OP_PUSH_FRONT) begin
						held.push_front(w.value);
					end else begin
						held.push_back(w.value);
					end
				end
				OP_POP_FRONT, OP_POP_BACK: begin
					if (held.size() == 0) begin
						e.result_value = EMPTY_POP_WORD;
						e.status       = ST_EMPTY;
					end else if (w.operation == OP_POP_FRONT) begin
						e.result_value = held.pop_front();
					end else begin
						e.result_value = held.pop_back();
					end
				end
				OP_SEARCH: begin
					foreach (held[i]) begin
						if (held[i] == w.value) begin
							e.found = 1'b1;
						end
					end
				end
				default: ;
			endcase
			e.occupancy = OCC_W'(held.size());
			expected_q.push_back(e);
		endfunction

		function void check_result(out_word_t got);
			out_word_t e;
			if (expected_q.size() == 0) begin
				note_failure($sformatf("result word with no command pending: %p", got));
				return;
			end
			e = expected_q.pop_front();
			if (got.result_value !== e.result_value || got.status !== e.status
					|| got.found !== e.found || got.occupancy !== e.occupancy) begin
				note_failure($sformatf(
					"exp val %0d st %0d fnd %0d occ %0d, got val %0d st %0d fnd %0d occ %0d",
					e.result_value, e.status, e.found, e.occupancy,
					got.result_value, got.status, got.found, got.occupancy));
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_word_t  cmd;
	logic      done;
	out_word_t result;

	deque_scoreboard          sb;
	logic signed [WORD_W-1:0] pool[8];
	int                       n_sent;
	int                       idle_cycles;

	double_ended_queue_with_search_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			sb.check_result(result);
		end
	end

	// stall watchdog
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic issue(logic [2:0] op, logic signed [WORD_W-1:0] v);
		in_word_t w;
		w.operation = op;
		w.value     = v;
		@(negedge clk);
		start = 1'b1;
		cmd   = w;
		do @(posedge clk); while (busy);
		sb.note_command(w);
		n_sent++;
	endtask

	task automatic pause(int n);
		if (n > 0) begin
			@(negedge clk);
			start         = 1'b0;
			cmd.operation = 3'($urandom);
			cmd.value     = $urandom;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic wait_all_results();
		@(negedge clk);
		start = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic int gap_len(bit no_gaps);
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic signed [WORD_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2: return -32'sd1;
			3: return 32'sd0;
			4, 5, 6: return pool[$urandom_range(0, 7)];
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] pick_op(mix_e mix);
		int r;
		int w_push;
		int w_pop;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_FILL:     begin w_push = 85; w_pop = 8;  end
			MIX_DRAIN:    begin w_push = 10; w_pop = 82; end
			MIX_BALANCED: begin w_push = 40; w_pop = 38; end
			default:      begin w_push = 22; w_pop = 18; end
		endcase
		if (r < 3) return 3'($urandom_range(OP_SEARCH + 1, OP_CODE_MAX));
		if (r < 3 + w_push) return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
		if (r < 3 + w_push + w_pop) return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
		return OP_SEARCH;
	endfunction

	initial begin
		logic [2:0]               op;
		logic signed [WORD_W-1:0] v;
		mix_e                     mix;
		int                       len;
		bit                       no_gaps;

		sb          = new();
		n_sent      = 0;
		arst_n      = 1'b0;
		start       = 1'b0;
		cmd         = '0;
		foreach (pool[i]) pool[i] = $urandom;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty queue corners, extremes, both ends, spare codes
		issue(OP_SEARCH, 32'sd0);
		issue(OP_POP_FRONT, 32'sd5);
		issue(OP_POP_BACK, 32'sd5);
		issue(OP_PUSH_FRONT, 32'sh7fff_ffff);
		issue(OP_PUSH_BACK, 32'sh8000_0000);
		issue(OP_PUSH_FRONT, -32'sd1);
		issue(OP_PUSH_BACK, 32'sd0);
		issue(OP_SEARCH, 32'sh8000_0000);
		issue(OP_SEARCH, 32'sh7fff_ffff);
		issue(OP_SEARCH, 32'sd12345);
		issue(OP_SEARCH, -32'sd1);
		for (logic [3:0] c = 4'(OP_SEARCH) + 4'd1; c <= OP_CODE_MAX; c++) begin
			issue(c[2:0], -32'sd1);
		end
		issue(OP_POP_BACK, 32'sd0);
		issue(OP_POP_FRONT, 32'sd0);
		issue(OP_POP_FRONT, 32'sd0);
		issue(OP_POP_BACK, 32'sd0);
		issue(OP_POP_BACK, 32'sd0);
		wait_all_results();

		// random phases, the first one weighted toward pushes to fill the queue
		mix = MIX_FILL;
		while (n_sent < N_WORDS) begin
			len     = $urandom_range(10, 80);
			no_gaps = ($urandom_range(0, 3) == 0);
			repeat (len) begin
				op = pick_op(mix);
				if (op == OP_SEARCH && $urandom_range(0, 1)) begin
					v = pool[$urandom_range(0, 7)];
				end else begin
					v = pick_value();
				end
				if ((op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && $urandom_range(0, 3) == 0) begin
					pool[$urandom_range(0, 7)] = v;
				end
				issue(op, v);
				pause(gap_len(no_gaps));
			end
			if ($urandom_range(0, 4) == 0) begin
				wait_all_results();
			end
			mix = mix_e'($urandom_range(0, 3));
		end

		wait_all_results();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
